// ===== rtl/acm_pkg.sv =====
// Shared types, constants and helpers for the argmax confusion-matrix accumulator.
// Used by every module under rtl/ except acm_ram; depends on nothing.
package acm_pkg;

   // Sizes
   localparam int MAX_CLASSES = 16;
   localparam int COUNT_WIDTH = 32;
   localparam int CLASS_W     = $clog2(MAX_CLASSES);
   localparam int INDEX_W     = $clog2(MAX_CLASSES + 1);
   localparam int NCLS_W      = 5;
   localparam int VALUE_W     = 16;
   localparam int OP_W        = 2;
   localparam int CELLS       = MAX_CLASSES * MAX_CLASSES;
   localparam int CELL_AW     = $clog2(CELLS);

   // Request operation codes
   localparam logic [OP_W-1:0] OP_ACCUMULATE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ       = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR      = 2'd2;

   // Response kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   localparam logic [NCLS_W-1:0] NUM_CLASSES_RESET = NCLS_W'(MAX_CLASSES);

   // Command from the front end to the back end
   typedef enum logic [1:0] {
      CMD_SAMPLE,
      CMD_READ,
      CMD_CLEAR
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type         op;
      logic [CLASS_W-1:0] row;
      logic [CLASS_W-1:0] col;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // One response beat
   typedef struct packed {
      logic                   kind;
      logic [CLASS_W-1:0]     target_class;
      logic [CLASS_W-1:0]     predicted_class;
      logic                   hit;
      logic [COUNT_WIDTH-1:0] cell_count;
      logic [COUNT_WIDTH-1:0] hits_total;
      logic [COUNT_WIDTH-1:0] samples_total;
   } rsp_type;

   // Saturating increment
   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
      return (&c) ? c : c + COUNT_WIDTH'(1);
   endfunction

endpackage

// ===== rtl/argmax_confusion_matrix_accumulator.sv =====
// Top level of the argmax confusion-matrix accumulator.
// Depends on acm_pkg, acm_front, acm_cmd_queue, acm_back and acm_ram.
//
// Accumulate beats enter at one per cycle while the command queue is not full;
// the front end tracks both argmaxes with a single compare per vector. Each
// finished sample and each cell read goes through the back end's idle state
// (registered RAM read) and then its data state (saturating update and write);
// a clear completes in the idle state. A four-entry command queue lets element
// beats keep flowing while the back end works, as long as finished samples and
// reads do not outpace the single RAM port. A two-entry response queue holds
// results while rsp_pop is low. The cells are cleared at reset and by a clear
// beat at once through per-cell valid bits, so there is no clearing pass.
// csr_num_classes must be written only while idle; the block does not enforce it.
module argmax_confusion_matrix_accumulator (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [acm_pkg::OP_W-1:0]           req_operation,
   input  logic signed [acm_pkg::VALUE_W-1:0] req_predicted_value,
   input  logic signed [acm_pkg::VALUE_W-1:0] req_target_value,
   input  logic                               req_last_element,
   input  logic [acm_pkg::CLASS_W-1:0]        req_read_row,
   input  logic [acm_pkg::CLASS_W-1:0]        req_read_column,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic                               rsp_kind,
   output logic [acm_pkg::CLASS_W-1:0]        rsp_target_class,
   output logic [acm_pkg::CLASS_W-1:0]        rsp_predicted_class,
   output logic                               rsp_hit,
   output logic [acm_pkg::COUNT_WIDTH-1:0]    rsp_cell_count,
   output logic [acm_pkg::COUNT_WIDTH-1:0]    rsp_hits_total,
   output logic [acm_pkg::COUNT_WIDTH-1:0]    rsp_samples_total,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [acm_pkg::NCLS_W-1:0]         csr_num_classes
);

   acm_pkg::queue_status_type q_status;
   acm_pkg::cmd_type          cmd_in, cmd_head;
   logic                      cmd_push, cmd_pop;
   acm_pkg::rsp_type          rsp;

   acm_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_operation       (req_operation),
      .req_predicted_value (req_predicted_value),
      .req_target_value    (req_target_value),
      .req_last_element    (req_last_element),
      .req_read_row        (req_read_row),
      .req_read_column     (req_read_column),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_num_classes     (csr_num_classes),
      .q_status            (q_status),
      .cmd_push            (cmd_push),
      .cmd                 (cmd_in)
   );

   acm_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd_in),
      .pop      (cmd_pop),
      .head     (cmd_head),
      .status   (q_status)
   );

   acm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   // Response fields
   assign rsp_kind            = rsp.kind;
   assign rsp_target_class    = rsp.target_class;
   assign rsp_predicted_class = rsp.predicted_class;
   assign rsp_hit             = rsp.hit;
   assign rsp_cell_count      = rsp.cell_count;
   assign rsp_hits_total      = rsp.hits_total;
   assign rsp_samples_total   = rsp.samples_total;

   // Checks
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response queue not empty after reset");

   a_hit_match: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == acm_pkg::KIND_SAMPLE)
         |-> (rsp_hit == (rsp_target_class == rsp_predicted_class)))
      else $error("hit flag disagrees with classes");

   a_read_no_hit: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == acm_pkg::KIND_READ) |-> !rsp_hit)
      else $error("read answer carries a hit");

   a_totals: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_hits_total <= rsp_samples_total))
      else $error("hit total exceeds sample total");

endmodule

// ===== rtl/acm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module acm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/acm_cmd_queue.sv =====
// Four-entry command queue between the front end and the back end.
// Depends on acm_pkg.
module acm_cmd_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  acm_pkg::cmd_type          push_cmd,
   input  logic                      pop,
   output acm_pkg::cmd_type          head,
   output acm_pkg::queue_status_type status
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   acm_pkg::cmd_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Payload storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.full  = (cnt_ff == CNT_W'(DEPTH));
   assign status.empty = (cnt_ff == '0);

endmodule

// ===== rtl/acm_front.sv =====
// Front end: takes request beats, keeps the running argmax of both vectors and
// issues sample, read and clear commands. Holds the num_classes register. Depends on acm_pkg.
module acm_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic [acm_pkg::OP_W-1:0]             req_operation,
   input  logic signed [acm_pkg::VALUE_W-1:0]   req_predicted_value,
   input  logic signed [acm_pkg::VALUE_W-1:0]   req_target_value,
   input  logic                                 req_last_element,
   input  logic [acm_pkg::CLASS_W-1:0]          req_read_row,
   input  logic [acm_pkg::CLASS_W-1:0]          req_read_column,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [acm_pkg::NCLS_W-1:0]           csr_num_classes,
   input  acm_pkg::queue_status_type            q_status,
   output logic                                 cmd_push,
   output acm_pkg::cmd_type                     cmd
);

   logic [acm_pkg::NCLS_W-1:0]          num_classes_ff, num_classes_in;
   logic [acm_pkg::NCLS_W-1:0]          ncls;
   logic [acm_pkg::INDEX_W-1:0]         index_ff, index_in;
   logic signed [acm_pkg::VALUE_W-1:0]  best_pv_ff, best_pv_in;
   logic signed [acm_pkg::VALUE_W-1:0]  best_tv_ff, best_tv_in;
   logic [acm_pkg::CLASS_W-1:0]         best_pi_ff, best_pi_in;
   logic [acm_pkg::CLASS_W-1:0]         best_ti_ff, best_ti_in;
   logic                                accept;

   assign csr_ready = 1'b1;
   assign req_full  = q_status.full;
   assign accept    = req_push && !q_status.full;

   // Configuration register
   always_comb begin
      num_classes_in = num_classes_ff;
      if (csr_valid) begin
         num_classes_in = csr_num_classes;
      end
   end

   // Effective class count: zero acts as one, above the store acts as full size
   always_comb begin
      if (num_classes_ff == '0) begin
         ncls = acm_pkg::NCLS_W'(1);
      end else if (num_classes_ff > acm_pkg::NCLS_W'(acm_pkg::MAX_CLASSES)) begin
         ncls = acm_pkg::NCLS_W'(acm_pkg::MAX_CLASSES);
      end else begin
         ncls = num_classes_ff;
      end
   end

   // Running argmax and command issue
   always_comb begin
      index_in   = index_ff;
      best_pv_in = best_pv_ff;
      best_pi_in = best_pi_ff;
      best_tv_in = best_tv_ff;
      best_ti_in = best_ti_ff;
      cmd_push   = 1'b0;
      cmd.op     = acm_pkg::CMD_SAMPLE;
      cmd.row    = req_read_row;
      cmd.col    = req_read_column;
      if (accept) begin
         case (req_operation)
            acm_pkg::OP_ACCUMULATE: begin
               // ties keep the first maximum
               if (acm_pkg::NCLS_W'(index_ff) < ncls) begin
                  if (index_ff == '0 || req_predicted_value > best_pv_ff) begin
                     best_pv_in = req_predicted_value;
                     best_pi_in = index_ff[acm_pkg::CLASS_W-1:0];
                  end
                  if (index_ff == '0 || req_target_value > best_tv_ff) begin
                     best_tv_in = req_target_value;
                     best_ti_in = index_ff[acm_pkg::CLASS_W-1:0];
                  end
               end
               // position counter stops at the store size
               if (index_ff < acm_pkg::INDEX_W'(acm_pkg::MAX_CLASSES)) begin
                  index_in = index_ff + acm_pkg::INDEX_W'(1);
               end
               if (req_last_element) begin
                  cmd_push   = 1'b1;
                  cmd.op     = acm_pkg::CMD_SAMPLE;
                  cmd.row    = best_ti_in;
                  cmd.col    = best_pi_in;
                  index_in   = '0;
                  best_pv_in = '0;
                  best_pi_in = '0;
                  best_tv_in = '0;
                  best_ti_in = '0;
               end
            end
            acm_pkg::OP_READ: begin
               cmd_push = 1'b1;
               cmd.op   = acm_pkg::CMD_READ;
            end
            acm_pkg::OP_CLEAR: begin
               // clear also drops a partial sample
               cmd_push   = 1'b1;
               cmd.op     = acm_pkg::CMD_CLEAR;
               index_in   = '0;
               best_pv_in = '0;
               best_pi_in = '0;
               best_tv_in = '0;
               best_ti_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_classes_ff <= acm_pkg::NUM_CLASSES_RESET;
         index_ff       <= '0;
         best_pv_ff     <= '0;
         best_pi_ff     <= '0;
         best_tv_ff     <= '0;
         best_ti_ff     <= '0;
      end else begin
         num_classes_ff <= num_classes_in;
         index_ff       <= index_in;
         best_pv_ff     <= best_pv_in;
         best_pi_ff     <= best_pi_in;
         best_tv_ff     <= best_tv_in;
         best_ti_ff     <= best_ti_in;
      end
   end

endmodule

// ===== rtl/acm_back.sv =====
// Back end: carries out commands against the confusion-matrix RAM, keeps the
// totals and queues response beats. Depends on acm_pkg and acm_ram.
module acm_back (
   input  logic                      clock,
   input  logic                      reset,
   input  acm_pkg::queue_status_type q_status,
   input  acm_pkg::cmd_type          cmd_head,
   output logic                      cmd_pop,
   input  logic                      rsp_pop,
   output logic                      rsp_empty,
   output acm_pkg::rsp_type          rsp
);

   localparam int OQ_DEPTH = 2;
   localparam int OQ_PW    = $clog2(OQ_DEPTH);
   localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

   typedef enum logic {
      ST_IDLE,
      ST_DATA
   } state_type;

   state_type                          state_ff, state_in;
   acm_pkg::cmd_type                   cur_ff, cur_in;
   logic                               cur_valid_ff, cur_valid_in;
   logic [acm_pkg::CELLS-1:0]          valid_ff, valid_in;
   logic [acm_pkg::COUNT_WIDTH-1:0]    hits_ff, hits_in;
   logic [acm_pkg::COUNT_WIDTH-1:0]    samples_ff, samples_in;
   acm_pkg::rsp_type                   oq_ff [OQ_DEPTH];
   logic [OQ_PW-1:0]                   oq_wr_ff, oq_wr_in;
   logic [OQ_PW-1:0]                   oq_rd_ff, oq_rd_in;
   logic [OQ_CW-1:0]                   oq_cnt_ff, oq_cnt_in;

   logic                               take;
   logic                               oq_push, oq_pop;
   logic [acm_pkg::CELL_AW-1:0]        rd_addr, wr_addr;
   logic                               wr_en;
   logic [acm_pkg::COUNT_WIDTH-1:0]    ram_q, cell_old, cell_new;
   logic                               is_sample, hit;
   acm_pkg::rsp_type                   beat;

   // Take a command only when a response slot is sure to be free
   assign take    = (state_ff == ST_IDLE) && !q_status.empty
                    && (oq_cnt_ff < OQ_CW'(OQ_DEPTH));
   assign cmd_pop = take;
   assign rd_addr = {cmd_head.row, cmd_head.col};
   assign wr_addr = {cur_ff.row, cur_ff.col};

   acm_ram #(
      .WIDTH (acm_pkg::COUNT_WIDTH),
      .DEPTH (acm_pkg::CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cell_new),
      .rd_en   (take),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Cell update and response beat
   always_comb begin
      is_sample = (cur_ff.op == acm_pkg::CMD_SAMPLE);
      hit       = is_sample && (cur_ff.row == cur_ff.col);
      cell_old  = cur_valid_ff ? ram_q : '0;
      cell_new  = is_sample ? acm_pkg::sat_inc(cell_old) : cell_old;
      wr_en     = (state_ff == ST_DATA) && is_sample;
      oq_push   = (state_ff == ST_DATA);

      beat.kind            = is_sample ? acm_pkg::KIND_SAMPLE : acm_pkg::KIND_READ;
      beat.target_class    = cur_ff.row;
      beat.predicted_class = cur_ff.col;
      beat.hit             = hit;
      beat.cell_count      = cell_new;
      beat.hits_total      = hits_in;
      beat.samples_total   = samples_in;
   end

   // Sequencer: issue a read, then finish in the data state; a clear completes in idle
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      valid_in     = valid_ff;
      hits_in      = hits_ff;
      samples_in   = samples_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (cmd_head.op == acm_pkg::CMD_CLEAR) begin
                  valid_in   = '0;
                  hits_in    = '0;
                  samples_in = '0;
               end else begin
                  cur_in       = cmd_head;
                  cur_valid_in = valid_ff[rd_addr];
                  state_in     = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (is_sample) begin
               valid_in[wr_addr] = 1'b1;
               samples_in        = acm_pkg::sat_inc(samples_ff);
               if (hit) begin
                  hits_in = acm_pkg::sat_inc(hits_ff);
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response queue pointers
   always_comb begin
      oq_pop    = rsp_pop && (oq_cnt_ff != '0);
      oq_wr_in  = oq_push ? oq_wr_ff + OQ_PW'(1) : oq_wr_ff;
      oq_rd_in  = oq_pop  ? oq_rd_ff + OQ_PW'(1) : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff + OQ_CW'(oq_push) - OQ_CW'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_valid_ff <= 1'b0;
         valid_ff     <= '0;
         hits_ff      <= '0;
         samples_ff   <= '0;
         oq_wr_ff     <= '0;
         oq_rd_ff     <= '0;
         oq_cnt_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         cur_valid_ff <= cur_valid_in;
         valid_ff     <= valid_in;
         hits_ff      <= hits_in;
         samples_ff   <= samples_in;
         oq_wr_ff     <= oq_wr_in;
         oq_rd_ff     <= oq_rd_in;
         oq_cnt_ff    <= oq_cnt_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= beat;
      end
   end

   assign rsp       = oq_ff[oq_rd_ff];
   assign rsp_empty = (oq_cnt_ff == '0);

endmodule

// ===== tb/tb_argmax_confusion_matrix_accumulator.sv =====
// Self-checking testbench for the argmax confusion-matrix accumulator.
// Needs acm_pkg and argmax_confusion_matrix_accumulator; a class tracks the
// expected cells and totals.
module tb_argmax_confusion_matrix_accumulator;
   import acm_pkg::*;

   // Opcode with no defined meaning; the block must drop it
   localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned HOLD_CYCLES   = 60;
   localparam int unsigned IDLE_PCT      = 37;
   localparam int unsigned REPORT_LIMIT  = 10;

   // Expected-result tracker: mirrors the argmax state and the cell store
   class confusion_tally;
      logic [NCLS_W-1:0]         classes_reg;
      logic [COUNT_WIDTH-1:0]    cells [CELLS];
      logic [INDEX_W-1:0]        position;
      logic signed [VALUE_W-1:0] top_pred_value;
      logic signed [VALUE_W-1:0] top_target_value;
      logic [CLASS_W-1:0]        top_pred_index;
      logic [CLASS_W-1:0]        top_target_index;
      logic [COUNT_WIDTH-1:0]    hit_total;
      logic [COUNT_WIDTH-1:0]    sample_total;
      rsp_type                   awaited [$];
      int unsigned checked, errors, samples, reads, clears, ignored;

      function new();
         classes_reg = NUM_CLASSES_RESET;
         clear_store();
      endfunction

      // Register value as the block uses it: 0 acts as 1, above the store acts as full size
      static function int unsigned clamp_classes(input logic [NCLS_W-1:0] v);
         if (v == 0) return 1;
         if (v > MAX_CLASSES) return MAX_CLASSES;
         return 32'(v);
      endfunction

      function logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
         return (c == '1) ? c : c + 1'b1;
      endfunction

      function void drop_sample();
         position         = '0;
         top_pred_value   = '0;
         top_target_value = '0;
         top_pred_index   = '0;
         top_target_index = '0;
      endfunction

      function void clear_store();
         foreach (cells[i]) cells[i] = '0;
         hit_total    = '0;
         sample_total = '0;
         drop_sample();
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      // One accepted request beat
      function void note_request(input logic [OP_W-1:0] op,
                                 input logic signed [VALUE_W-1:0] pv,
                                 input logic signed [VALUE_W-1:0] tv,
                                 input logic last,
                                 input logic [CLASS_W-1:0] row,
                                 input logic [CLASS_W-1:0] col);
         rsp_type             beat;
         logic [CELL_AW-1:0]  cell_addr;
         case (op)
            OP_ACCUMULATE: begin
               // elements past the class count do not vote
               if (position < clamp_classes(classes_reg)) begin
                  if (position == 0 || pv > top_pred_value) begin
                     top_pred_value = pv;
                     top_pred_index = position[CLASS_W-1:0];
                  end
                  if (position == 0 || tv > top_target_value) begin
                     top_target_value = tv;
                     top_target_index = position[CLASS_W-1:0];
                  end
               end
               if (position < MAX_CLASSES) position = position + 1'b1;
               if (last) begin
                  cell_addr = {top_target_index, top_pred_index};
                  cells[cell_addr] = bump(cells[cell_addr]);
                  sample_total = bump(sample_total);
                  beat.hit     = (top_target_index == top_pred_index);
                  if (beat.hit) hit_total = bump(hit_total);
                  beat.kind            = KIND_SAMPLE;
                  beat.target_class    = top_target_index;
                  beat.predicted_class = top_pred_index;
                  beat.cell_count      = cells[cell_addr];
                  beat.hits_total      = hit_total;
                  beat.samples_total   = sample_total;
                  awaited.push_back(beat);
                  samples++;
                  drop_sample();
               end
            end
            OP_READ: begin
               beat.kind            = KIND_READ;
               beat.target_class    = row;
               beat.predicted_class = col;
               beat.hit             = 1'b0;
               beat.cell_count      = cells[{row, col}];
               beat.hits_total      = hit_total;
               beat.samples_total   = sample_total;
               awaited.push_back(beat);
               reads++;
            end
            OP_CLEAR: begin
               clear_store();
               clears++;
            end
            default: ignored++;
         endcase
      endfunction

      // One accepted result beat against the oldest expectation
      function void check_result(input rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("[%0t] result with nothing expected: kind=%0d cell=%0d",
                        $realtime, got.kind, got.cell_count);
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.kind !== want.kind || got.target_class !== want.target_class ||
             got.predicted_class !== want.predicted_class || got.hit !== want.hit ||
             got.cell_count !== want.cell_count || got.hits_total !== want.hits_total ||
             got.samples_total !== want.samples_total) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
               $display({"[%0t] mismatch: exp kind=%0d tgt=%0d pred=%0d hit=%0d",
                         " cell=%0d hits=%0d smp=%0d"},
                        $realtime, want.kind, want.target_class, want.predicted_class,
                        want.hit, want.cell_count, want.hits_total, want.samples_total);
               $display({"              act kind=%0d tgt=%0d pred=%0d hit=%0d",
                         " cell=%0d hits=%0d smp=%0d"},
                        got.kind, got.target_class, got.predicted_class,
                        got.hit, got.cell_count, got.hits_total, got.samples_total);
            end
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   logic                        req_full;
   logic [OP_W-1:0]             req_operation = '0;
   logic signed [VALUE_W-1:0]   req_predicted_value = '0;
   logic signed [VALUE_W-1:0]   req_target_value = '0;
   logic                        req_last_element = 1'b0;
   logic [CLASS_W-1:0]          req_read_row = '0;
   logic [CLASS_W-1:0]          req_read_column = '0;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic                        rsp_kind;
   logic [CLASS_W-1:0]          rsp_target_class;
   logic [CLASS_W-1:0]          rsp_predicted_class;
   logic                        rsp_hit;
   logic [COUNT_WIDTH-1:0]      rsp_cell_count;
   logic [COUNT_WIDTH-1:0]      rsp_hits_total;
   logic [COUNT_WIDTH-1:0]      rsp_samples_total;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [NCLS_W-1:0]           csr_num_classes = '0;

   confusion_tally tally = new();
   int unsigned    send_idle_pct = IDLE_PCT;
   int unsigned    pop_idle_pct  = IDLE_PCT;
   bit             hold_request  = 1'b0;
   int unsigned    offered_items = 0;
   int unsigned    setting_count = 0;
   int unsigned    cycle_count   = 0;

   argmax_confusion_matrix_accumulator i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_operation       (req_operation),
      .req_predicted_value (req_predicted_value),
      .req_target_value    (req_target_value),
      .req_last_element    (req_last_element),
      .req_read_row        (req_read_row),
      .req_read_column     (req_read_column),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_kind            (rsp_kind),
      .rsp_target_class    (rsp_target_class),
      .rsp_predicted_class (rsp_predicted_class),
      .rsp_hit             (rsp_hit),
      .rsp_cell_count      (rsp_cell_count),
      .rsp_hits_total      (rsp_hits_total),
      .rsp_samples_total   (rsp_samples_total),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_num_classes     (csr_num_classes)
   );

   // Clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, tally.pending());
      $display("Verification failed");
      $finish;
   end

   // Beat monitor: results first, then new requests, then register writes
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty)
            tally.check_result('{kind: rsp_kind, target_class: rsp_target_class,
                                 predicted_class: rsp_predicted_class, hit: rsp_hit,
                                 cell_count: rsp_cell_count, hits_total: rsp_hits_total,
                                 samples_total: rsp_samples_total});
         if (req_push && !req_full)
            tally.note_request(req_operation, req_predicted_value, req_target_value,
                               req_last_element, req_read_row, req_read_column);
         if (csr_valid && csr_ready)
            tally.classes_reg = csr_num_classes;
      end
   end

   // Result side: random pops, plus a long hold-off on request
   initial begin : result_drain
      int unsigned hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
         end
      end
   end

   // Drive one request beat, idling first at random, return at the accepting edge
   task automatic send_beat(input logic [OP_W-1:0] op,
                            input logic signed [VALUE_W-1:0] pv,
                            input logic signed [VALUE_W-1:0] tv,
                            input logic last,
                            input logic [CLASS_W-1:0] row,
                            input logic [CLASS_W-1:0] col);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push            <= 1'b1;
      req_operation       <= op;
      req_predicted_value <= pv;
      req_target_value    <= tv;
      req_last_element    <= last;
      req_read_row        <= row;
      req_read_column     <= col;
      do @(posedge clock); while (req_full);
      if (op != OP_IGNORED) offered_items++;
   endtask

   task automatic send_element(input logic signed [VALUE_W-1:0] pv,
                               input logic signed [VALUE_W-1:0] tv,
                               input logic last);
      send_beat(OP_ACCUMULATE, pv, tv, last, CLASS_W'($urandom), CLASS_W'($urandom));
   endtask

   task automatic send_read(input logic [CLASS_W-1:0] row, input logic [CLASS_W-1:0] col);
      send_beat(OP_READ, VALUE_W'($urandom), VALUE_W'($urandom), 1'($urandom), row, col);
   endtask

   // Stop offering, wait out every expected result, then let the back end go quiet
   task automatic settle();
      req_push <= 1'b0;
      while (tally.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_classes(input logic [NCLS_W-1:0] value);
      settle();
      csr_valid       <= 1'b1;
      csr_num_classes <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   // Values biased toward ties and the two ends of the range
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(5))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2, 3:    return VALUE_W'($urandom_range(6)) - 16'sd3;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // Mostly cells inside the active matrix, sometimes anywhere in the store
   function automatic logic [CLASS_W-1:0] pick_class(input int unsigned n_cls);
      if ($urandom_range(3) == 0) return CLASS_W'($urandom);
      return CLASS_W'($urandom_range(n_cls - 1));
   endfunction

   // One class setting followed by random traffic, mostly well-formed samples
   task automatic run_phase(input logic [NCLS_W-1:0] setting, input int unsigned quota,
                            input bit squeeze);
      int unsigned first, n_cls, len, choice, i;
      write_classes(setting);
      n_cls = confusion_tally::clamp_classes(setting);
      if (squeeze) begin
         send_idle_pct = 0;
         pop_idle_pct  = 0;
         hold_request  = 1'b1;
      end
      first = offered_items;
      while (offered_items - first < quota) begin
         choice = $urandom_range(99);
         if (choice < 78) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : n_cls;
            for (i = 0; i < len; i++) begin
               if ($urandom_range(29) == 0) send_read(pick_class(n_cls), pick_class(n_cls));
               send_element(pick_value(), pick_value(), i == len - 1);
            end
         end else if (choice < 90) begin
            send_read(pick_class(n_cls), pick_class(n_cls));
         end else if (choice < 94) begin
            send_element(pick_value(), pick_value(), 1'($urandom));
         end else if (choice < 96) begin
            send_beat(OP_IGNORED, pick_value(), pick_value(), 1'($urandom),
                      CLASS_W'($urandom), CLASS_W'($urandom));
         end else if (choice < 97) begin
            send_beat(OP_CLEAR, pick_value(), pick_value(), 1'($urandom),
                      CLASS_W'($urandom), CLASS_W'($urandom));
         end else begin
            send_beat(OP_W'($urandom), pick_value(), pick_value(), 1'($urandom),
                      CLASS_W'($urandom), CLASS_W'($urandom));
         end
      end
      send_idle_pct = IDLE_PCT;
      pop_idle_pct  = IDLE_PCT;
   endtask

   // Stimulus
   initial begin : stimulus
      logic [NCLS_W-1:0] plan [8];
      int unsigned       k;
      plan = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd1, 5'd17, 5'd2, NCLS_W'($urandom_range(5, 15))};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty store, one-element sample at the value extremes
      send_read(4'd0, 4'd0);
      send_element(16'sh8000, 16'sh7FFF, 1'b1);
      // all-equal vectors: first index wins
      send_element(16'sd5, 16'sd5, 1'b0);
      send_element(16'sd5, 16'sd5, 1'b0);
      send_element(16'sd5, 16'sd5, 1'b1);
      // maximum on the final element
      send_element(-16'sd1, 16'sd0, 1'b0);
      send_element(16'sh8000, 16'sd0, 1'b0);
      send_element(16'sh7FFF, 16'sd0, 1'b1);
      // read in the middle of a sample keeps the partial argmax
      send_element(16'sd100, 16'sd7, 1'b0);
      send_read(4'd2, 4'd0);
      send_element(16'sd200, -16'sd5, 1'b1);
      // clear in the middle of a sample drops it
      send_element(16'sd50, 16'sd50, 1'b0);
      send_beat(OP_CLEAR, 16'sd0, 16'sd0, 1'b1, 4'hF, 4'hF);
      send_element(-16'sd7, -16'sd9, 1'b1);
      // undefined opcode does nothing
      send_beat(OP_IGNORED, 16'sh7FFF, 16'sh8000, 1'b1, 4'hF, 4'hF);
      send_read(4'hF, 4'hF);
      send_read(4'd0, 4'd0);
      // three classes: larger values past the third element are ignored
      write_classes(5'd3);
      send_element(16'sd1, 16'sd3, 1'b0);
      send_element(16'sd2, 16'sd2, 1'b0);
      send_element(16'sd3, 16'sd1, 1'b0);
      send_element(16'sd9, 16'sd9, 1'b0);
      send_element(16'sd9, 16'sd9, 1'b1);
      send_read(4'd0, 4'd2);

      // Random phases over several class settings; the single-class one runs
      // flat out with a long result hold-off so the request side backs up
      for (k = 0; k < 8; k++) run_phase(plan[k], 220, k == 4);

      settle();
      $display("Covered %0d request beats over %0d class settings:",
               offered_items + tally.ignored, setting_count);
      $display("  %0d samples, %0d reads, %0d clears, %0d ignored ops",
               tally.samples, tally.reads, tally.clears, tally.ignored);
      $display("Checked %0d results in %0d cycles, %0d mismatches",
               tally.checked, cycle_count, tally.errors);
      if (tally.errors == 0 && tally.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/acm_pkg.sv
rtl/acm_ram.sv
rtl/acm_cmd_queue.sv
rtl/acm_front.sv
rtl/acm_back.sv
rtl/argmax_confusion_matrix_accumulator.sv
tb/tb_argmax_confusion_matrix_accumulator.sv
